@@ rtl/core/lef_pkg.sv @@
// lef_pkg: shared types and constants of the laplacian edge filter
// holds the command word passed from the front end, the result word and register codes
// no dependencies
package lef_pkg;

	localparam int PIX_W  = 24;
	localparam int CH_W   = 8;
	localparam int COL_W  = 10;
	localparam int ROW_W  = 12;
	localparam int CFG_W  = 13;
	localparam int FW_W   = 11;
	localparam int FH_W   = 13;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	// register indexes of the configuration port
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

	// classified item from the front end
	typedef struct packed {
		logic               pix;       // shifts the window and updates the line store
		logic               emit;      // gives one result word
		logic               interior;  // result uses the window, otherwise zero
		logic               last;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		logic [PIX_W-1:0]   px;        // {red, green, blue}
	} cmd_t;

	typedef struct packed {
		logic               last;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic [CH_W-1:0]    blue;
		logic [CH_W-1:0]    green;
		logic [CH_W-1:0]    red;
	} res_t;

endpackage

@@ rtl/core/lef_front.sv @@
// lef_front: accepts words, keeps frame position, drain and completion state
// registers the classified command for the back end; depends on lef_pkg
module lef_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [lef_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         accept,
	input  logic                         op_flush,
	input  logic [lef_pkg::PIX_W-1:0]    px,
	output logic                         valid_s1,
	output lef_pkg::cmd_t                cmd_s1,
	output logic [$clog2(MAX_WIDTH)-1:0] addr_s1
);
	import lef_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int EW  = CW + 1;
	localparam int EH  = RW + 1;
	localparam int EW2 = EW + 1;
	localparam int EH2 = EH + 1;
	localparam int WXW = (EW > FW_W) ? EW : FW_W;
	localparam int HXW = (EH > FH_W) ? EH : FH_W;

	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic [CW-1:0]   in_col_q, out_col_q;
	logic [RW-1:0]   in_row_q, out_row_q;
	logic            frame_done_q, draining_q;

	logic [EW-1:0]   eff_w;
	logic [EH-1:0]   eff_h;
	logic            flush, pixel, restart, due, emit, interior;
	logic            in_end_col, in_end_row, end_col, last;
	logic [CW-1:0]   c, oc, in_col_n, out_col_n;
	logic [RW-1:0]   r, orow, in_row_n, out_row_n;

	always_comb begin
		if (frame_width_q == '0) begin
			eff_w = EW'(1);
		end else if (WXW'(frame_width_q) > WXW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			eff_h = EH'(1);
		end else if (HXW'(frame_height_q) > HXW'(MAX_HEIGHT)) begin
			eff_h = EH'(MAX_HEIGHT);
		end else begin
			eff_h = EH'(frame_height_q);
		end
	end

	always_comb begin
		// a pixel while draining acts as a flush
		flush   = op_flush | draining_q;
		pixel   = ~flush;
		restart = pixel & frame_done_q;
		c       = restart ? '0 : in_col_q;
		r       = restart ? '0 : in_row_q;
		oc      = restart ? '0 : out_col_q;
		orow    = restart ? '0 : out_row_q;

		due  = (r >= RW'(2)) || ((r == RW'(1)) && (c != '0));
		emit = flush ? draining_q : due;

		interior = pixel && (oc != '0) && (EW2'(oc) + EW2'(2) <= EW2'(eff_w))
			&& (orow != '0) && (EH2'(orow) + EH2'(2) <= EH2'(eff_h));
		end_col = (EW'(oc) + EW'(1)) >= eff_w;
		last    = end_col && ((EH'(orow) + EH'(1)) >= eff_h);

		in_end_col = (EW'(c) + EW'(1)) >= eff_w;
		in_end_row = (EH'(r) + EH'(1)) >= eff_h;
		in_col_n   = in_end_col ? '0 : c + CW'(1);
		in_row_n   = in_end_col ? (in_end_row ? '0 : r + RW'(1)) : r;

		if (!emit) begin
			out_col_n = oc;
			out_row_n = orow;
		end else if (last) begin
			out_col_n = '0;
			out_row_n = '0;
		end else if (end_col) begin
			out_col_n = '0;
			out_row_n = orow + RW'(1);
		end else begin
			out_col_n = oc + CW'(1);
			out_row_n = orow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default:          frame_width_q  <= frame_width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q     <= '0;
			in_row_q     <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			frame_done_q <= 1'b0;
			draining_q   <= 1'b0;
			valid_s1     <= 1'b0;
		end else begin
			valid_s1 <= accept & (pixel | emit);
			if (accept) begin
				out_col_q <= out_col_n;
				out_row_q <= out_row_n;
				if (pixel) begin
					in_col_q     <= in_col_n;
					in_row_q     <= in_row_n;
					frame_done_q <= emit & last;
					draining_q   <= in_end_col & in_end_row & ~(emit & last);
				end else begin
					frame_done_q <= frame_done_q | (emit & last);
					draining_q   <= draining_q & ~(emit & last);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.pix      <= pixel;
			cmd_s1.emit     <= emit;
			cmd_s1.interior <= interior;
			cmd_s1.last     <= last;
			cmd_s1.col      <= COL_W'(oc);
			cmd_s1.row      <= ROW_W'(orow);
			cmd_s1.px       <= px;
			addr_s1         <= c;
		end
	end

endmodule

@@ rtl/core/lef_core.sv @@
// lef_core: line store, 3x3 window and laplacian kernel
// takes commands from lef_front and pushes result words; depends on lef_pkg
module lef_core #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_s1,
	input  lef_pkg::cmd_t                cmd_s1,
	input  logic [$clog2(MAX_WIDTH)-1:0] addr_s1,
	output logic [1:0]                   emit_pending,
	output logic                         push,
	output lef_pkg::res_t                push_data
);
	import lef_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int LW = 2 * PIX_W;

	// each entry holds {row r-2, row r-1} of one column
	logic [LW-1:0]    line_mem [MAX_WIDTH];
	logic [LW-1:0]    rd_s2, fwd_data_s2, lines;
	logic             fwd_s2;
	logic             valid_s2, valid_s3;
	cmd_t             cmd_s2, cmd_s3;
	logic [CW-1:0]    addr_s2;
	logic [PIX_W-1:0] win_q [3][3];
	logic             wr;
	logic [LW-1:0]    wdata;
	logic [10:0]      neg [3];
	logic [10:0]      pos [3];
	logic [10:0]      diff [3];
	logic [CH_W-1:0]  lap [3];

	assign lines = fwd_s2 ? fwd_data_s2 : rd_s2;
	assign wr    = valid_s2 & cmd_s2.pix;
	assign wdata = {lines[PIX_W-1:0], cmd_s2.px};

	always_ff @(posedge clk) begin
		if (valid_s1 & cmd_s1.pix) begin
			rd_s2 <= line_mem[addr_s1];
		end
		if (wr) begin
			line_mem[addr_s2] <= wdata;
		end
		fwd_data_s2 <= wdata;
		cmd_s2      <= cmd_s1;
		addr_s2     <= addr_s1;
		cmd_s3      <= cmd_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			fwd_s2   <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			// same column read while the previous pixel writes it
			fwd_s2   <= wr & valid_s1 & cmd_s1.pix & (addr_s1 == addr_s2);
			if (wr) begin
				for (int i = 0; i < 3; i++) begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[0][2] <= lines[LW-1:PIX_W];
				win_q[1][2] <= lines[PIX_W-1:0];
				win_q[2][2] <= cmd_s2.px;
			end
		end
	end

	// 8*center minus the neighbors, clamped to 0..255
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			neg[ch] = '0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (i != 1 || j != 1) begin
						neg[ch] = neg[ch] + 11'(win_q[i][j][ch*CH_W +: CH_W]);
					end
				end
			end
			pos[ch]  = {win_q[1][1][ch*CH_W +: CH_W], 3'b000};
			diff[ch] = pos[ch] - neg[ch];
			if (neg[ch] > pos[ch]) begin
				lap[ch] = '0;
			end else if (diff[ch] > 11'd255) begin
				lap[ch] = '1;
			end else begin
				lap[ch] = diff[ch][CH_W-1:0];
			end
		end
	end

	always_comb begin
		push            = valid_s3 & cmd_s3.emit;
		push_data.red   = cmd_s3.interior ? lap[2] : '0;
		push_data.green = cmd_s3.interior ? lap[1] : '0;
		push_data.blue  = cmd_s3.interior ? lap[0] : '0;
		push_data.col   = cmd_s3.col;
		push_data.row   = cmd_s3.row;
		push_data.last  = cmd_s3.last;
	end

	assign emit_pending = 2'(valid_s2 & cmd_s2.emit) + 2'(valid_s3 & cmd_s3.emit);

endmodule

@@ rtl/core/lef_queue.sv @@
// lef_queue: result queue between the kernel and the output channel
// register-based fifo whose head drives the output; depends on lef_pkg
module lef_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  lef_pkg::res_t              push_data,
	input  logic                       pop,
	output logic                       not_empty,
	output lef_pkg::res_t              head,
	output logic [lef_pkg::QLVL_W-1:0] level
);
	import lef_pkg::*;

	res_t              fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QLVL_W-1:0] level_q;
	logic              do_pop;

	assign not_empty = level_q != '0;
	assign do_pop    = pop & not_empty;
	assign head      = fifo_q[rd_ptr_q];
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			level_q <= level_q + QLVL_W'(push) - QLVL_W'(do_pop);
		end
	end

endmodule

@@ rtl/core/laplacian_edge_filter_rgb.sv @@
// laplacian_edge_filter_rgb: top level of the 3x3 laplacian edge filter for rgb streams
// joins lef_front, lef_core and lef_queue; depends on lef_pkg
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tdata pixel, s_tuser flush flag
//  m_*       out        m_tvalid/m_tready  m_tdata result pixel, m_tlast end of frame
//  cfg_*     in         cfg_we             cfg_index, cfg_data
//
// one word per cycle while s_tready is high; results pass s1, s2, s3 and the queue
// the line store is one memory with a registered read and a write per cycle, with forwarding
// reset clears counters, window and queue; the line store is not cleared
// input stalls only when the result queue plus words in flight would exceed its depth
module laplacian_edge_filter_rgb #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
	input  logic        s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // red_out, green_out, blue_out, column, row, zero pad
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);
	import lef_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic              accept, valid_s1;
	cmd_t              cmd_s1;
	logic [CW-1:0]     addr_s1;
	logic [1:0]        emit_pending;
	logic              push;
	res_t              push_data, head;
	logic [QLVL_W-1:0] level;
	logic [QLVL_W:0]   committed;

	// every word in flight already owns a queue slot
	assign committed = (QLVL_W+1)'(level) + (QLVL_W+1)'(emit_pending)
		+ (QLVL_W+1)'(valid_s1 & cmd_s1.emit);
	assign s_tready  = committed < (QLVL_W+1)'(QUEUE_DEPTH);
	assign accept    = s_tvalid & s_tready;

	lef_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.op_flush  (s_tuser),
		.px        ({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}),
		.valid_s1  (valid_s1),
		.cmd_s1    (cmd_s1),
		.addr_s1   (addr_s1)
	);

	lef_core #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.cmd_s1       (cmd_s1),
		.addr_s1      (addr_s1),
		.emit_pending (emit_pending),
		.push         (push),
		.push_data    (push_data)
	);

	lef_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (m_tready),
		.not_empty (m_tvalid),
		.head      (head),
		.level     (level)
	);

	assign m_tdata = {2'b00, head.row, head.col, head.blue, head.green, head.red};
	assign m_tlast = head.last;

endmodule

@@ rtl/core/lef_checker.sv @@
// lef_checker: port-level assertions for laplacian_edge_filter_rgb
// bound to the top level below; no package dependency
module lef_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tlast
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// left border column gives zero samples
	a_col0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[33:24] == 10'd0) |-> (m_tdata[23:0] == 24'd0))
		else $error("nonzero result on left border");

	// top border row gives zero samples
	a_row0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[45:34] == 12'd0) |-> (m_tdata[23:0] == 24'd0))
		else $error("nonzero result on top border");

	// nothing is shown right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result shown right after reset");

endmodule

bind laplacian_edge_filter_rgb lef_checker u_lef_checker (.*);

@@ test/laplacian_edge_filter_rgb_check.sv @@
// laplacian_edge_filter_rgb_check: watches the stream and config ports of the edge filter,
// predicts every result word and compares it field by field with what the block gives
// depends on lef_pkg
module laplacian_edge_filter_rgb_check
	import lef_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
	input  logic        s_tuser,   // operation
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // red_out, green_out, blue_out, column, row, zero pad
	input  logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	output int          mismatches,
	output int          results_due
);

	localparam int LINE_DEPTH = 1024;
	localparam int MAX_ROWS   = 4096;
	localparam int COL_LSB    = 3 * CH_W;
	localparam int ROW_LSB    = COL_LSB + COL_W;

	logic [PIX_W-1:0] row_minus2 [LINE_DEPTH];
	logic [PIX_W-1:0] row_minus1 [LINE_DEPTH];
	logic [PIX_W-1:0] win [3][3];
	int unsigned      in_col, in_row, out_col, out_row;
	bit               frame_done, draining;
	logic [FW_W-1:0]  width_reg;
	logic [FH_W-1:0]  height_reg;
	res_t             edge_results_due [$];

	function automatic int unsigned cols_in_use();
		if (width_reg == 0) return 1;
		if (width_reg > LINE_DEPTH) return LINE_DEPTH;
		return width_reg;
	endfunction

	function automatic int unsigned rows_in_use();
		if (height_reg == 0) return 1;
		if (height_reg > MAX_ROWS) return MAX_ROWS;
		return height_reg;
	endfunction

	// 8 * center minus the eight neighbors of one channel, clamped to 0..255
	function automatic logic [CH_W-1:0] edge_strength(int sh);
		int sum;
		sum = 8 * int'(win[1][1][sh +: CH_W]);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				if (i != 1 || j != 1)
					sum -= int'(win[i][j][sh +: CH_W]);
		if (sum < 0) sum = 0;
		if (sum > 255) sum = 255;
		return CH_W'(sum);
	endfunction

	task automatic queue_result(bit use_win);
		int unsigned w, h;
		bit interior, end_col, last;
		res_t r;
		w = cols_in_use();
		h = rows_in_use();
		interior = use_win && out_col >= 1 && out_col + 2 <= w &&
			out_row >= 1 && out_row + 2 <= h;
		end_col = out_col + 1 >= w;
		last = end_col && out_row + 1 >= h;
		r.red   = interior ? edge_strength(0) : '0;
		r.green = interior ? edge_strength(CH_W) : '0;
		r.blue  = interior ? edge_strength(2 * CH_W) : '0;
		r.col   = out_col[COL_W-1:0];
		r.row   = out_row[ROW_W-1:0];
		r.last  = last;
		edge_results_due.push_back(r);
		if (last) begin
			out_col = 0;
			out_row = 0;
			frame_done = 1'b1;
			draining = 1'b0;
		end else if (end_col) begin
			out_col = 0;
			out_row = out_row + 1;
		end else begin
			out_col = out_col + 1;
		end
	endtask

	task automatic predict_word(bit flush, logic [PIX_W-1:0] px);
		int unsigned w, h, c, r;
		logic [PIX_W-1:0] top, mid;
		bit due;
		w = cols_in_use();
		h = rows_in_use();
		top = '0;
		mid = '0;
		// a pixel during the drain only pushes the next pending result out
		if (flush || draining) begin
			if (draining && !frame_done)
				queue_result(1'b0);
		end else begin
			if (frame_done) begin
				frame_done = 1'b0;
				in_col = 0;
				in_row = 0;
				out_col = 0;
				out_row = 0;
			end
			c = in_col;
			r = in_row;
			if (c < LINE_DEPTH) begin
				top = row_minus2[c];
				mid = row_minus1[c];
				row_minus2[c] = mid;
				row_minus1[c] = px;
			end
			for (int i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = top;
			win[1][2] = mid;
			win[2][2] = px;
			// a result is due once width+2 pixels of the frame are in
			due = r >= 2 || (r == 1 && c >= 1);
			if (c + 1 >= w) begin
				in_col = 0;
				if (r + 1 >= h) begin
					in_row = 0;
					draining = 1'b1;
				end else begin
					in_row = r + 1;
				end
			end else begin
				in_col = c + 1;
			end
			if (due)
				queue_result(1'b1);
		end
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int k = 0; k < LINE_DEPTH; k++) begin
				row_minus2[k] = '0;
				row_minus1[k] = '0;
			end
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					win[i][j] = '0;
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
			frame_done = 1'b0;
			draining = 1'b0;
			width_reg = FRAME_WIDTH_RST;
			height_reg = FRAME_HEIGHT_RST;
			edge_results_due.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FRAME_WIDTH)
					width_reg = cfg_data[FW_W-1:0];
				else if (cfg_index == REG_FRAME_HEIGHT)
					height_reg = cfg_data[FH_W-1:0];
			end
			if (s_tvalid && s_tready)
				predict_word(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (edge_results_due.size() == 0) begin
					report_mismatch("result word with none expected, column",
						m_tdata[COL_LSB +: COL_W], -1);
				end else begin
					want = edge_results_due.pop_front();
					if (m_tdata[0 +: CH_W] !== want.red)
						report_mismatch("red", m_tdata[0 +: CH_W], want.red);
					if (m_tdata[CH_W +: CH_W] !== want.green)
						report_mismatch("green", m_tdata[CH_W +: CH_W], want.green);
					if (m_tdata[2*CH_W +: CH_W] !== want.blue)
						report_mismatch("blue", m_tdata[2*CH_W +: CH_W], want.blue);
					if (m_tdata[COL_LSB +: COL_W] !== want.col)
						report_mismatch("column", m_tdata[COL_LSB +: COL_W], want.col);
					if (m_tdata[ROW_LSB +: ROW_W] !== want.row)
						report_mismatch("row", m_tdata[ROW_LSB +: ROW_W], want.row);
					if (m_tlast !== want.last)
						report_mismatch("frame last", m_tlast, want.last);
				end
			end
		end
		results_due = edge_results_due.size();
	end

endmodule

@@ test/laplacian_edge_filter_rgb_test.sv @@
// laplacian_edge_filter_rgb_test: drives frames, flushes and register writes into the
// edge filter with random idling on both sides and gives the verdict
// depends on lef_pkg, laplacian_edge_filter_rgb and laplacian_edge_filter_rgb_check
module laplacian_edge_filter_rgb_test;
	import lef_pkg::*;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam int LIMIT_CYCLES  = 1500000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 1150;
	localparam int QUIET_ITEMS   = 300;
	localparam int HOLD_AFTER    = 100;
	localparam int HOLD_CYCLES   = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // red_in, green_in, blue_in
	logic        s_tuser = 1'b0; // operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // red_out, green_out, blue_out, column, row, zero pad
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [12:0] cfg_data = '0;

	int mismatches;
	int results_due;
	int cycle_count = 0;
	int results_taken = 0;
	int words_sent = 0;
	int gap_odds = 0;
	bit no_stall = 1'b0;
	bit hold_done = 1'b0;

	laplacian_edge_filter_rgb dut (.*);
	laplacian_edge_filter_rgb_check chk (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		if (m_tvalid && m_tready)
			results_taken <= results_taken + 1;

	// receiver: random stalls, one long hold-off so the block backs up its input
	initial begin
		int held;
		bit stall_phase;
		stall_phase = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0)
				stall_phase = !stall_phase;
			if (!hold_done && results_taken >= HOLD_AFTER) begin
				m_tready <= 1'b0;
				held = 0;
				while (held < HOLD_CYCLES) begin
					@(posedge clk);
					held++;
				end
				hold_done = 1'b1;
				m_tready <= 1'b1;
			end else if (!no_stall && stall_phase && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic int size_in_use(int raw, int ceiling);
		if (raw == 0) return 1;
		if (raw > ceiling) return ceiling;
		return raw;
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 3))
			0: return {$urandom_range(0, 1) ? 8'hff : 8'h00,
				$urandom_range(0, 1) ? 8'hff : 8'h00,
				$urandom_range(0, 1) ? 8'hff : 8'h00};
			// nearly flat area, small edge values
			1: return {CH_W'($urandom_range(96, 104)), CH_W'($urandom_range(96, 104)),
				CH_W'($urandom_range(96, 104))};
			default: return PIX_W'($urandom);
		endcase
	endfunction

	task automatic send_word(input logic op, input logic [PIX_W-1:0] px);
		if (!no_stall && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= px;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
	endtask

	// sender holds back until every predicted word is out and the pipe is quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_frame(input int unsigned w_raw, input int unsigned h_raw);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= CFG_W'(w_raw);
		@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data <= CFG_W'(h_raw);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_pixels(input int count, input int noise_odds);
		repeat (count) begin
			// flush while the frame is still coming in gives nothing
			if (noise_odds != 0 && $urandom_range(1, noise_odds) == 1)
				send_word(OP_FLUSH, PIX_W'($urandom));
			send_word(OP_PIXEL, pick_pixel());
		end
	endtask

	// pending results come out on flushes or on pixels that arrive while draining
	task automatic drain_frame(input int count, input int extra);
		repeat (count)
			send_word($urandom_range(0, 3) == 0 ? OP_PIXEL : OP_FLUSH, PIX_W'($urandom));
		repeat (extra)
			send_word(OP_FLUSH, PIX_W'($urandom));
	endtask

	initial begin
		int w, h, cells, frames, first_random;
		logic [CH_W-1:0] red, green, blue;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// flush right after reset gives nothing
		send_word(OP_FLUSH, '0);

		// 3x3 frame: one interior pixel, clamped high on red, low on green, small on blue
		set_frame(3, 3);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				red = ((r + c) % 2 == 0) ? 8'hff : 8'h00;
				green = ~red;
				blue = (r == 1 && c == 1) ? 8'h21 : 8'h20;
				send_word(OP_PIXEL, {blue, green, red});
			end
		send_word(OP_FLUSH, '0);
		send_word(OP_FLUSH, '0);
		send_word(OP_PIXEL, 24'hffffff);
		send_word(OP_FLUSH, '0);
		send_word(OP_FLUSH, '0);

		// zero width and height act as one
		set_frame(0, 0);
		send_word(OP_PIXEL, 24'hffffff);
		send_word(OP_FLUSH, '0);
		send_word(OP_FLUSH, '0);

		// width shrinks in the first row and wraps the column at once
		set_frame(5, 3);
		send_pixels(2, 0);
		set_frame(3, 3);
		send_pixels(7, 0);
		drain_frame(4, 1);

		// raw sizes above the limits, then a narrow width wraps the long first row
		set_frame(2047, 8191);
		send_pixels(4, 0);
		set_frame(3, 2);
		send_pixels(4, 0);
		drain_frame(4, 1);

		// a wide frame keeps the sender busy while the receiver holds off
		gap_odds = 4;
		set_frame(40, 12);
		send_pixels(480, 0);
		drain_frame(41, 1);

		frames = 0;
		first_random = words_sent;
		w = 1;
		h = 1;
		while (words_sent < first_random + RANDOM_ITEMS) begin
			if (words_sent >= first_random + RANDOM_ITEMS - QUIET_ITEMS)
				no_stall = 1'b1;
			if (frames == 0 || $urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 19))
					0: w = 0;
					1, 2: w = $urandom_range(11, 40);
					default: w = $urandom_range(1, 10);
				endcase
				case ($urandom_range(0, 19))
					0: h = 0;
					1, 2: h = $urandom_range(7, 12);
					default: h = $urandom_range(1, 6);
				endcase
				set_frame(w, h);
			end
			gap_odds = $urandom_range(0, 1) ? 0 : $urandom_range(2, 8);
			cells = size_in_use(w, 1024) * size_in_use(h, 4096);
			send_pixels(cells, $urandom_range(0, 2) == 0 ? 8 : 0);
			drain_frame(cells < size_in_use(w, 1024) + 1 ? cells : size_in_use(w, 1024) + 1,
				$urandom_range(0, 2));
			frames++;
		end

		settle();
		if (mismatches == 0 && results_due == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/lef_pkg.sv
rtl/core/lef_front.sv
rtl/core/lef_core.sv
rtl/core/lef_queue.sv
rtl/core/laplacian_edge_filter_rgb.sv
rtl/core/lef_checker.sv
test/laplacian_edge_filter_rgb_check.sv
test/laplacian_edge_filter_rgb_test.sv
